[hdl/scs_pkg.sv]
// Shared types, character codes and defaults for the script comment stripper.
package scs_pkg;

   localparam int HOLD_DEPTH_DEF = 60;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;

   typedef enum logic [1:0] {
      LEX_CODE,
      LEX_SQ,
      LEX_DQ,
      LEX_CMT
   } lex_mode_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_FLUSH,
      CTRL_TAIL
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic emit_direct;
      logic flush_emit;
      logic tail_emit;
   } dp_cmd_type;

   typedef struct packed {
      logic       plan_flush;
      logic [1:0] plan_tail_n;
      logic       flush_last;
      logic       tail_last;
      logic       out_free;
   } dp_sts_type;

endpackage

[hdl/script_comment_stripper_top.sv]
// Top level of the script comment stripper: controller plus datapath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_in_byte, req_end_of_file
//   rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_last_of_run
//   csr      in         csr_wr_en             csr_wr_data (drop blank lines)
//
// While rsp is not stalled, plain text streams at one byte per cycle. An item
// that releases N held blanks and T further bytes (T up to three) emits the
// blanks first and then the bytes: the output register takes one byte per
// cycle and the blank store is read at one entry per cycle.
// Reset is synchronous; the blank store needs no clearing pass after it.
// A stall on rsp holds the result and the sequencer; req_stall is high while an
// item's results are still being produced.
module script_comment_stripper_top #(
   parameter int HOLD_DEPTH = scs_pkg::HOLD_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   scs_pkg::dp_cmd_type cmd;
   scs_pkg::dp_sts_type sts;

   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   scs_datapath #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

[hdl/scs_ram.sv]
// Generic simple dual-port RAM with registered read data.
module scs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/scs_datapath.sv]
// Datapath: lexer state, held-blank store, per-item emit plan and output register.
module scs_datapath #(
   parameter int HOLD_DEPTH = scs_pkg::HOLD_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_file,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  scs_pkg::dp_cmd_type cmd,
   output scs_pkg::dp_sts_type sts
);

   localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

   // Lexer and line state.
   scs_pkg::lex_mode_type mode_ff, mode_in;
   logic                  esc_ff, esc_in;
   logic                  content_ff, content_in;
   logic                  drop_ff, drop_in;
   logic [CNT_W-1:0]      held_cnt_ff, held_cnt_in;

   // Work of the item in progress.
   logic [CNT_W-1:0]      flush_cnt_ff, flush_cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [2:0][7:0]       tail_ff, tail_in;
   logic [1:0]            tail_n_ff, tail_n_in;
   logic [1:0]            tail_k_ff, tail_k_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Plan for the offered item.
   scs_pkg::lex_mode_type p_mode;
   logic                  p_esc, p_cont, p_flush, p_hold_wr, p_run_end;
   logic [CNT_W-1:0]      p_held;
   logic [2:0][7:0]       p_tail;
   logic [1:0]            p_n;
   logic                  is_ws, is_sq, is_dq;

   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic                  ram_rd_data;
   logic                  flush_last, tail_last, out_free;

   assign is_ws = (req_in_byte == scs_pkg::CH_SPACE) || (req_in_byte == scs_pkg::CH_TAB);
   assign is_sq = (req_in_byte == scs_pkg::CH_SQUOTE);
   assign is_dq = (req_in_byte == scs_pkg::CH_DQUOTE);

   // Each path that emits anything flushes held blanks first, so the held run always
   // leads the item's results and up to three bytes follow it.
   always_comb begin
      p_mode    = mode_ff;
      p_esc     = esc_ff;
      p_cont    = content_ff;
      p_held    = held_cnt_ff;
      p_flush   = 1'b0;
      p_hold_wr = 1'b0;
      p_run_end = 1'b0;
      p_tail    = '0;
      p_n       = 2'd0;
      if (req_in_byte == scs_pkg::CH_NL) begin
         p_run_end = 1'b1;
      end else begin
         unique case (mode_ff)
            scs_pkg::LEX_CODE: begin
               if (req_in_byte == scs_pkg::CH_HASH) begin
                  p_mode = scs_pkg::LEX_CMT;
               end else if (is_sq || is_dq) begin
                  p_flush   = 1'b1;
                  p_tail[p_n] = req_in_byte;
                  p_n       = p_n + 2'd1;
                  p_cont    = 1'b1;
                  p_mode    = is_sq ? scs_pkg::LEX_SQ : scs_pkg::LEX_DQ;
               end else if (is_ws) begin
                  if (content_ff || !drop_ff) begin
                     p_flush   = 1'b1;
                     p_tail[p_n] = req_in_byte;
                     p_n       = p_n + 2'd1;
                  end else if (held_cnt_ff == CNT_W'(HOLD_DEPTH)) begin
                     p_flush   = 1'b1;
                     p_tail[p_n] = req_in_byte;
                     p_n       = p_n + 2'd1;
                     p_cont    = 1'b1;
                  end else begin
                     p_hold_wr = 1'b1;
                     p_held    = held_cnt_ff + CNT_W'(1);
                  end
               end else begin
                  p_flush   = 1'b1;
                  p_tail[p_n] = req_in_byte;
                  p_n       = p_n + 2'd1;
                  p_cont    = 1'b1;
               end
            end
            scs_pkg::LEX_SQ, scs_pkg::LEX_DQ: begin
               p_flush   = 1'b1;
               p_tail[p_n] = req_in_byte;
               p_n       = p_n + 2'd1;
               p_cont    = 1'b1;
               if (esc_ff) begin
                  p_esc = 1'b0;
               end else if (req_in_byte == scs_pkg::CH_BSLASH) begin
                  p_esc = 1'b1;
               end else if ((mode_ff == scs_pkg::LEX_SQ && is_sq) ||
                            (mode_ff == scs_pkg::LEX_DQ && is_dq)) begin
                  p_mode = scs_pkg::LEX_CODE;
               end
            end
            scs_pkg::LEX_CMT: begin
            end
            default: begin
            end
         endcase
         p_run_end = req_end_of_file;
      end
      if (p_run_end) begin
         // An open quote is closed at the end of the line.
         if (p_mode == scs_pkg::LEX_SQ) begin
            p_flush   = 1'b1;
            p_tail[p_n] = scs_pkg::CH_SQUOTE;
            p_n       = p_n + 2'd1;
            p_cont    = 1'b1;
         end else if (p_mode == scs_pkg::LEX_DQ) begin
            p_flush   = 1'b1;
            p_tail[p_n] = scs_pkg::CH_DQUOTE;
            p_n       = p_n + 2'd1;
            p_cont    = 1'b1;
         end
         if (p_cont || !drop_ff) begin
            p_flush   = 1'b1;
            p_tail[p_n] = scs_pkg::CH_NL;
            p_n       = p_n + 2'd1;
         end
         p_mode = scs_pkg::LEX_CODE;
         p_esc  = 1'b0;
         p_cont = 1'b0;
      end
   end

   assign flush_last = (CNT_W'(idx_ff) + CNT_W'(1)) == flush_cnt_ff;
   assign tail_last  = (tail_k_ff + 2'd1) == tail_n_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign sts.plan_flush  = p_flush && (held_cnt_ff != '0);
   assign sts.plan_tail_n = p_n;
   assign sts.flush_last  = flush_last;
   assign sts.tail_last   = tail_last;
   assign sts.out_free    = out_free;

   // The first held blank is read while the item is taken; each emitted blank
   // fetches the next one.
   assign ram_rd_en   = cmd.accept || (cmd.flush_emit && !flush_last);
   assign ram_rd_addr = cmd.accept ? '0 : IDX_W'(idx_ff + IDX_W'(1));

   scs_ram #(
      .WIDTH (1),
      .DEPTH (HOLD_DEPTH)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && p_hold_wr),
      .wr_addr (held_cnt_ff[IDX_W-1:0]),
      .wr_data (req_in_byte == scs_pkg::CH_TAB),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      mode_in      = mode_ff;
      esc_in       = esc_ff;
      content_in   = content_ff;
      held_cnt_in  = held_cnt_ff;
      drop_in      = csr_wr_en ? csr_wr_data : drop_ff;
      flush_cnt_in = flush_cnt_ff;
      idx_in       = idx_ff;
      tail_in      = tail_ff;
      tail_n_in    = tail_n_ff;
      tail_k_in    = tail_k_ff;
      if (cmd.accept) begin
         mode_in      = p_mode;
         esc_in       = p_esc;
         content_in   = p_cont;
         held_cnt_in  = (p_flush || p_run_end) ? '0 : p_held;
         flush_cnt_in = held_cnt_ff;
         idx_in       = '0;
         tail_in      = p_tail;
         tail_n_in    = p_n;
         tail_k_in    = 2'd0;
      end
      if (cmd.flush_emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.tail_emit) begin
         tail_k_in = tail_k_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (cmd.emit_direct) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = p_tail[0];
         rsp_last_in  = 1'b1;
      end else if (cmd.flush_emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = ram_rd_data ? scs_pkg::CH_TAB : scs_pkg::CH_SPACE;
         rsp_last_in  = 1'b0;
      end else if (cmd.tail_emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = tail_ff[tail_k_ff];
         rsp_last_in  = tail_last;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= scs_pkg::LEX_CODE;
         esc_ff       <= 1'b0;
         content_ff   <= 1'b0;
         held_cnt_ff  <= '0;
         drop_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         esc_ff       <= esc_in;
         content_ff   <= content_in;
         held_cnt_ff  <= held_cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_cnt_ff <= flush_cnt_in;
      idx_ff       <= idx_in;
      tail_ff      <= tail_in;
      tail_n_ff    <= tail_n_in;
      tail_k_ff    <= tail_k_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[hdl/scs_ctrl.sv]
// Controller: sequences held-blank flushes and trailing bytes of each item.
module scs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  scs_pkg::dp_sts_type sts,
   output scs_pkg::dp_cmd_type cmd
);

   scs_pkg::ctrl_state_type state_ff, state_in;
   logic                    direct;

   // A single result with nothing held goes straight to a free output register.
   assign direct = !sts.plan_flush && (sts.plan_tail_n == 2'd1) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scs_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               if (sts.plan_flush) begin
                  state_in = scs_pkg::CTRL_FLUSH;
               end else if (sts.plan_tail_n != 2'd0 && !direct) begin
                  state_in = scs_pkg::CTRL_TAIL;
               end
            end
         end
         scs_pkg::CTRL_FLUSH: begin
            if (sts.out_free && sts.flush_last) begin
               state_in = scs_pkg::CTRL_TAIL;
            end
         end
         scs_pkg::CTRL_TAIL: begin
            if (sts.out_free && sts.tail_last) begin
               state_in = scs_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = scs_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall       = 1'b1;
      cmd.accept      = 1'b0;
      cmd.emit_direct = 1'b0;
      cmd.flush_emit  = 1'b0;
      cmd.tail_emit   = 1'b0;
      unique case (state_ff)
         scs_pkg::CTRL_IDLE: begin
            req_stall       = 1'b0;
            cmd.accept      = req_valid;
            cmd.emit_direct = req_valid && direct;
         end
         scs_pkg::CTRL_FLUSH: begin
            cmd.flush_emit = sts.out_free;
         end
         scs_pkg::CTRL_TAIL: begin
            cmd.tail_emit = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scs_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/scs_checker.sv]
// Port-level assertions for the script comment stripper and their bind.
module scs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   // A newline always closes the run of results of its item.
   a_nl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte == scs_pkg::CH_NL |-> rsp_last_of_run)
      else $error("newline result not marked last");

   // The block becomes ready again only once an item's last result is out.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) && !$past(reset) |-> rsp_valid && rsp_last_of_run)
      else $error("input ready before last result of the item");

endmodule

bind script_comment_stripper_top scs_checker u_scs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

[tb/sv/tb_script_comment_stripper_top.sv]
// Self-checking testbench for the script comment stripper top level.
`timescale 1ns / 100ps

module tb_script_comment_stripper_top;

   localparam int HOLD_DEPTH    = scs_pkg::HOLD_DEPTH_DEF;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      logic [7:0] ch;
      logic       eof;
   } script_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } strip_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_file = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // Bytes still to be offered, and stripped bytes still to come out.
   script_byte_type script_q[$];
   strip_out_type   stripped_q[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int rx_hold_left = 0;
   int phase_items = 0;
   int err_cnt = 0;
   int cycle_cnt = 0;
   logic req_taken = 1'b0;

   // Shadow state of the stripper.
   logic                  drop_blanks;
   scs_pkg::lex_mode_type lex;
   logic                  esc_pending;
   logic                  line_busy;
   int                    blanks_held;
   logic                  blank_is_tab [HOLD_DEPTH];

   script_comment_stripper_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void put_byte(logic [7:0] ch);
      strip_out_type e;
      e.ch = ch;
      e.last = 1'b0;
      stripped_q.push_back(e);
   endfunction

   function automatic void release_blanks();
      for (int i = 0; i < blanks_held; i++)
         put_byte(blank_is_tab[i] ? scs_pkg::CH_TAB : scs_pkg::CH_SPACE);
      blanks_held = 0;
   endfunction

   function automatic void put_content(logic [7:0] ch);
      release_blanks();
      line_busy = 1'b1;
      put_byte(ch);
   endfunction

   // An open quote is closed, then the newline goes out unless the line is blank
   // and blank lines are being removed.
   function automatic void close_line();
      if (lex == scs_pkg::LEX_SQ)
         put_content(scs_pkg::CH_SQUOTE);
      else if (lex == scs_pkg::LEX_DQ)
         put_content(scs_pkg::CH_DQUOTE);
      if (line_busy || !drop_blanks) begin
         release_blanks();
         put_byte(scs_pkg::CH_NL);
      end
      lex = scs_pkg::LEX_CODE;
      esc_pending = 1'b0;
      line_busy = 1'b0;
      blanks_held = 0;
   endfunction

   function automatic void strip_predict(logic [7:0] ch, logic eof);
      int            n0;
      strip_out_type tail;
      n0 = stripped_q.size();
      if (ch == scs_pkg::CH_NL) begin
         close_line();
      end else begin
         case (lex)
            scs_pkg::LEX_CODE: begin
               if (ch == scs_pkg::CH_HASH) begin
                  lex = scs_pkg::LEX_CMT;
               end else if (ch == scs_pkg::CH_SQUOTE) begin
                  put_content(ch);
                  lex = scs_pkg::LEX_SQ;
               end else if (ch == scs_pkg::CH_DQUOTE) begin
                  put_content(ch);
                  lex = scs_pkg::LEX_DQ;
               end else if (ch == scs_pkg::CH_SPACE || ch == scs_pkg::CH_TAB) begin
                  if (line_busy || !drop_blanks) begin
                     release_blanks();
                     put_byte(ch);
                  end else if (blanks_held >= HOLD_DEPTH) begin
                     put_content(ch);
                  end else begin
                     blank_is_tab[blanks_held] = (ch == scs_pkg::CH_TAB);
                     blanks_held++;
                  end
               end else begin
                  put_content(ch);
               end
            end
            scs_pkg::LEX_SQ, scs_pkg::LEX_DQ: begin
               put_content(ch);
               if (esc_pending)
                  esc_pending = 1'b0;
               else if (ch == scs_pkg::CH_BSLASH)
                  esc_pending = 1'b1;
               else if ((lex == scs_pkg::LEX_SQ && ch == scs_pkg::CH_SQUOTE) ||
                        (lex == scs_pkg::LEX_DQ && ch == scs_pkg::CH_DQUOTE))
                  lex = scs_pkg::LEX_CODE;
            end
            default: ;
         endcase
         if (eof)
            close_line();
      end
      if (stripped_q.size() > n0) begin
         tail = stripped_q[stripped_q.size() - 1];
         tail.last = 1'b1;
         stripped_q[stripped_q.size() - 1] = tail;
      end
   endfunction

   // Sender: a stalled item holds its payload until it is taken.
   always @(negedge clock) begin
      script_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (script_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = script_q.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= nxt.ch;
            req_end_of_file <= nxt.eof;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver, with an optional long hold-off counted down here.
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: predicts on every taken item first, then checks any result.
   always @(posedge clock) begin
      strip_out_type want;
      if (reset) begin
         drop_blanks = 1'b1;
         lex = scs_pkg::LEX_CODE;
         esc_pending = 1'b0;
         line_busy = 1'b0;
         blanks_held = 0;
         req_taken = 1'b0;
      end else begin
         if (csr_wr_en)
            drop_blanks = csr_wr_data;
         req_taken = req_valid && !req_stall;
         if (req_taken)
            strip_predict(req_in_byte, req_end_of_file);
         if (rsp_valid && !rsp_stall) begin
            if (stripped_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, got byte %02h last %0b",
                        $time, rsp_out_byte, rsp_last_of_run);
               err_cnt++;
            end else begin
               want = stripped_q.pop_front();
               if (rsp_out_byte !== want.ch || rsp_last_of_run !== want.last) begin
                  $display("%0t: mismatch: expected byte %02h last %0b, %s %02h last %0b",
                           $time, want.ch, want.last, "got byte",
                           rsp_out_byte, rsp_last_of_run);
                  err_cnt++;
               end
            end
         end
      end
   end

   function automatic void push_script_byte(logic [7:0] ch, logic eof);
      script_byte_type it;
      it.ch = ch;
      it.eof = eof;
      script_q.push_back(it);
      phase_items++;
   endfunction

   function automatic void push_text(string s, logic eof_last);
      for (int i = 0; i < s.len(); i++)
         push_script_byte(s[i], eof_last && (i == s.len() - 1));
   endfunction

   function automatic logic [7:0] rand_blank();
      return $urandom_range(1) ? scs_pkg::CH_TAB : scs_pkg::CH_SPACE;
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'h61 + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_noise();
      logic [7:0] v;
      do
         v = 8'($urandom_range(255));
      while (v == scs_pkg::CH_NL);
      return v;
   endfunction

   // One line of script: leading blanks, a few tokens, then an ending that is
   // usually a newline, sometimes end of file, and now and then missing.
   function automatic void add_script_line();
      logic [7:0] chars[$];
      logic [7:0] q;
      int r, lead, ntok, n;
      r = $urandom_range(99);
      if (r < 2) begin
         // A full hold store released by a quote at end of file: the widest burst.
         repeat (HOLD_DEPTH) push_script_byte(rand_blank(), 1'b0);
         push_script_byte($urandom_range(1) ? scs_pkg::CH_SQUOTE : scs_pkg::CH_DQUOTE,
                          1'b1);
         return;
      end
      if (r < 7)
         lead = $urandom_range(HOLD_DEPTH + 3, HOLD_DEPTH - 2);
      else if (r < 55)
         lead = $urandom_range(4, 1);
      else
         lead = 0;
      repeat (lead) chars.push_back(rand_blank());
      ntok = $urandom_range(4);
      for (int k = 0; k < ntok; k++) begin
         case ($urandom_range(9))
            0, 1, 2: repeat ($urandom_range(5, 1)) chars.push_back(rand_letter());
            3: repeat ($urandom_range(3, 1)) chars.push_back(rand_blank());
            4, 5: begin
               q = $urandom_range(1) ? scs_pkg::CH_SQUOTE : scs_pkg::CH_DQUOTE;
               chars.push_back(q);
               n = $urandom_range(6);
               for (int j = 0; j < n; j++) begin
                  case ($urandom_range(5))
                     0: begin
                        chars.push_back(scs_pkg::CH_BSLASH);
                        chars.push_back(rand_noise());
                     end
                     1: chars.push_back(scs_pkg::CH_BSLASH);
                     2: chars.push_back(scs_pkg::CH_HASH);
                     3: chars.push_back(q == scs_pkg::CH_SQUOTE ? scs_pkg::CH_DQUOTE
                                                                : scs_pkg::CH_SQUOTE);
                     4: chars.push_back(rand_blank());
                     default: chars.push_back(rand_letter());
                  endcase
               end
               if ($urandom_range(3) != 0)
                  chars.push_back(q);
            end
            6: begin
               chars.push_back(scs_pkg::CH_HASH);
               repeat ($urandom_range(6)) chars.push_back(rand_noise());
            end
            7: repeat ($urandom_range(3, 1)) chars.push_back(rand_noise());
            default: begin
               case ($urandom_range(3))
                  0: chars.push_back(scs_pkg::CH_HASH);
                  1: chars.push_back(scs_pkg::CH_SQUOTE);
                  2: chars.push_back(scs_pkg::CH_DQUOTE);
                  default: chars.push_back(scs_pkg::CH_BSLASH);
               endcase
            end
         endcase
      end
      r = $urandom_range(99);
      for (int j = 0; j < chars.size(); j++)
         push_script_byte(chars[j], r >= 80 && r < 95 && j == chars.size() - 1);
      if (r < 80 || (r < 95 && chars.size() == 0))
         push_script_byte(scs_pkg::CH_NL, r >= 70);
   endfunction

   task automatic fill_random(int count);
      phase_items = 0;
      while (phase_items < count)
         add_script_line();
   endtask

   // Waits until every item is taken and every stripped byte has arrived, then
   // lets the block finish any item that yields nothing.
   task automatic wait_idle();
      @(posedge clock);
      while (script_q.size() != 0 || req_valid || stripped_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_drop(logic value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on the reset setting, where blank lines are dropped.
      push_text(" \tx#'\n", 1'b0);
      push_text("\t \n", 1'b0);
      push_text("'a\\'#\n", 1'b0);
      push_text("\"b\\\n", 1'b0);
      push_text("z", 1'b1);
      push_text("\n", 1'b1);
      push_script_byte(8'h00, 1'b0);
      push_script_byte(8'hFF, 1'b0);
      push_script_byte(8'h0D, 1'b1);
      // These blanks stay held across the switch to keeping blank lines.
      push_text(" \t", 1'b0);
      wait_idle();

      write_drop(1'b0);
      fill_random(80);
      wait_idle();

      write_drop(1'b1);
      send_idle_pct = 62;
      fill_random(80);
      wait_idle();

      // Long receiver hold-off so the output side fills and the input stalls.
      write_drop(1'b0);
      send_idle_pct = 0;
      stall_pct = 62;
      rx_hold_left = 300;
      push_text("abcdefghijkl\n", 1'b0);
      fill_random(80);
      wait_idle();

      write_drop(1'b1);
      send_idle_pct = 32;
      stall_pct = 32;
      fill_random(40);
      wait_idle();
      fill_random(40);
      wait_idle();

      if (stripped_q.size() != 0) begin
         $display("%0t: %0d stripped bytes never arrived, first expected %02h",
                  $time, stripped_q.size(), stripped_q[0].ch);
         err_cnt++;
      end
      if (err_cnt == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
